@@ hw/rtl/awah_pkg.sv @@
// Shared widths, register codes, constants and request types for the window average block.
package awah_pkg;

	// Field widths.
	localparam int ADC_W     = 10;
	localparam int MV_W      = 12;
	localparam int FS_W      = 10;
	localparam int PCT_W     = 13;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;

	// Largest ADC code; it sets how wide the running sum must be.
	localparam int ADC_MAX = (1 << ADC_W) - 1;

	// Serial arithmetic sizes: the product avg * ref is the widest dividend.
	localparam int PROD_W     = ADC_W + MV_W;
	localparam int DIV_W      = PROD_W;
	localparam int DVR_W      = 12;
	localparam int DIV_STEPS  = DIV_W / 2;
	localparam int MUL_STEPS  = ADC_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int MUL_CNT_W  = $clog2(MUL_STEPS);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_REF_MV     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_MV    = 2'd2;

	// Register reset values.
	localparam logic [MV_W-1:0] REF_MV_RST  = 12'd3000;
	localparam logic [FS_W-1:0] FS_RST      = 10'd1023;
	localparam logic [MV_W-1:0] SPAN_MV_RST = 12'd1000;

	// Saturation limits and the percent scale.
	localparam logic [MV_W-1:0] MV_MAX    = 12'd4095;
	localparam logic [MV_W-1:0] PCT_MAX   = 12'd4095;
	localparam logic [6:0]      PCT_SCALE = 7'd100;

	// Start request for the shared serial divider.
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVR_W-1:0] divisor;
	} div_req_t;

	// Start request for the serial multiplier.
	typedef struct packed {
		logic             start;
		logic [ADC_W-1:0] mplier;
		logic [MV_W-1:0]  mcand;
	} mul_req_t;

endpackage

@@ hw/rtl/awah_mul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module awah_mul import awah_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mul_req_t          req,
	output logic              done,
	output logic [PROD_W-1:0] product
);

	logic [PROD_W-1:0]    acc_q;
	logic [PROD_W-1:0]    mcand_q;
	logic [ADC_W-1:0]     mplier_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Each step adds the shifted multiplicand when the low multiplier bit is set.
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			mcand_q  <= PROD_W'(req.mcand);
			mplier_q <= req.mplier;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[ADC_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

@@ hw/rtl/awah_div.sv @@
// Restoring serial divider that retires two quotient bits per cycle.
module awah_div import awah_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0]     num_q;
	logic [DVR_W-1:0]     rem_q;
	logic [DVR_W-1:0]     dvr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W-1:0]     num_nx;
	logic [DVR_W-1:0]     rem_nx;

	// Two compare-and-subtract steps; quotient bits shift in behind the dividend.
	// A zero divisor yields an all-ones quotient.
	always_comb begin
		logic [DVR_W:0] trial;
		num_nx = num_q;
		rem_nx = rem_q;
		trial  = '0;
		for (int k = 0; k < 2; k++) begin
			trial  = {rem_nx, num_nx[DIV_W-1]};
			num_nx = {num_nx[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, dvr_q}) begin
				trial     = trial - {1'b0, dvr_q};
				num_nx[0] = 1'b1;
			end
			rem_nx = trial[DVR_W-1:0];
		end
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Datapath shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			rem_q <= '0;
			dvr_q <= req.divisor;
		end else if (busy_q) begin
			num_q <= num_nx;
			rem_q <= rem_nx;
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

@@ hw/rtl/awah_ring.sv @@
// Sample ring memory with write pointer, fill flag and running sum.
module awah_ring import awah_pkg::*; #(
	parameter int WINDOW = 100
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [ADC_W-1:0] sample,
	input  logic             commit,
	output logic [DIV_W-1:0] sum,
	output logic             full
);

	localparam int SUM_W = $clog2(WINDOW * ADC_MAX + 1);
	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

	logic [ADC_W-1:0] ring_mem [WINDOW];
	logic [ADC_W-1:0] old_s1;
	logic [ADC_W-1:0] new_s1;
	logic [ADC_W-1:0] old_val;
	logic [IDX_W-1:0] wr_idx_q;
	logic [SUM_W-1:0] sum_q;
	logic             full_q;

	// Read the oldest entry when the beat is taken; keep the new sample beside it.
	always_ff @(posedge clk) begin
		if (take) begin
			old_s1 <= ring_mem[wr_idx_q];
			new_s1 <= sample;
		end
	end

	// Overwrite the oldest entry in the cycle after the beat is taken.
	always_ff @(posedge clk) begin
		if (commit) begin
			ring_mem[wr_idx_q] <= new_s1;
		end
	end

	// Writes go in order, so an entry is unwritten until the first wrap and counts as zero.
	assign old_val = full_q ? old_s1 : '0;

	// Running sum, pointer and fill flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			wr_idx_q <= '0;
			full_q   <= 1'b0;
		end else if (commit) begin
			sum_q <= sum_q - SUM_W'(old_val) + SUM_W'(new_s1);
			if (wr_idx_q == LAST_IDX) begin
				wr_idx_q <= '0;
				full_q   <= 1'b1;
			end else begin
				wr_idx_q <= wr_idx_q + 1'b1;
			end
		end
	end

	assign sum  = DIV_W'(sum_q);
	assign full = full_q;

endmodule

@@ hw/rtl/adc_window_average_height.sv @@
// Top level: boxcar average of ADC samples, millivolt level, reference and percent height.
// Flow: a new input beat is taken only in the idle state, once the last result is loaded for output;
// each item uses the shared serial divider (average, millivolt and, once calibrated, percent
// passes) and the serial multiplier.
// Reset: asynchronous active low; configuration returns to defaults, ring reads as zero
// until each entry is first written, reference and calibrated flag clear.
module adc_window_average_height import awah_pkg::*; #(
	parameter int WINDOW = 100
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_idx,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [ADC_W-1:0]        adc_sample,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [MV_W-1:0]         level_mv,
	output logic [MV_W-1:0]         reference_mv,
	output logic signed [PCT_W-1:0] height_percent,
	output logic                    calibrated
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_UPD  = 4'd1;
	localparam logic [3:0] S_AVG  = 4'd2;
	localparam logic [3:0] S_AVGW = 4'd3;
	localparam logic [3:0] S_MULW = 4'd4;
	localparam logic [3:0] S_LVLW = 4'd5;
	localparam logic [3:0] S_HGT  = 4'd6;
	localparam logic [3:0] S_HGTW = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	logic [3:0]              state_q;
	logic [MV_W-1:0]         ref_mv_q;
	logic [FS_W-1:0]         fs_q;
	logic [MV_W-1:0]         span_q;
	logic [MV_W-1:0]         ref_lvl_q;
	logic                    cal_q;
	logic [MV_W-1:0]         level_q;
	logic signed [PCT_W-1:0] height_q;
	logic                    out_valid_q;
	logic [MV_W-1:0]         level_o_q;
	logic [MV_W-1:0]         ref_o_q;
	logic signed [PCT_W-1:0] height_o_q;
	logic                    cal_o_q;

	logic                    in_take;
	logic [DIV_W-1:0]        ring_sum;
	logic                    ring_full;
	div_req_t                div_req;
	logic                    div_done;
	logic [DIV_W-1:0]        quotient;
	mul_req_t                mul_req;
	logic                    mul_done;
	logic [PROD_W-1:0]       product;
	logic                    q_big;
	logic [MV_W-1:0]         level_sat;
	logic [MV_W-1:0]         hmag_sat;
	logic [PCT_W-1:0]        diff;
	logic [PCT_W-1:0]        diff_abs;
	logic                    diff_neg;
	logic [DIV_W-1:0]        hgt_dividend;

	assign in_ready = (state_q == S_IDLE);
	assign in_take  = in_valid && in_ready;

	awah_ring #(
		.WINDOW(WINDOW)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (in_take),
		.sample (adc_sample),
		.commit (state_q == S_UPD),
		.sum    (ring_sum),
		.full   (ring_full)
	);

	awah_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (quotient)
	);

	awah_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.done    (mul_done),
		.product (product)
	);

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_mv_q <= REF_MV_RST;
			fs_q     <= FS_RST;
			span_q   <= SPAN_MV_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_REF_MV:     ref_mv_q <= cfg_data[MV_W-1:0];
				REG_FULL_SCALE: fs_q     <= cfg_data[FS_W-1:0];
				REG_SPAN_MV:    span_q   <= cfg_data[MV_W-1:0];
				default: ;
			endcase
		end
	end

	// Quotient saturation, shared by the level and height passes.
	assign q_big     = |quotient[DIV_W-1:MV_W];
	assign level_sat = q_big ? MV_MAX : quotient[MV_W-1:0];
	assign hmag_sat  = q_big ? PCT_MAX : quotient[MV_W-1:0];

	// Signed reference minus level, as sign and magnitude.
	assign diff         = {1'b0, ref_lvl_q} - {1'b0, level_q};
	assign diff_neg     = diff[PCT_W-1];
	assign diff_abs     = diff_neg ? (PCT_W'(0) - diff) : diff;
	assign hgt_dividend = DIV_W'(diff_abs[MV_W-1:0]) * DIV_W'(PCT_SCALE);

	// Divider requests: average, millivolt conversion, percent height.
	always_comb begin
		div_req = '0;
		case (state_q)
			S_AVG: begin
				div_req.start    = 1'b1;
				div_req.dividend = ring_sum;
				div_req.divisor  = DVR_W'(WINDOW);
			end
			S_MULW: begin
				div_req.start    = mul_done;
				div_req.dividend = DIV_W'(product);
				div_req.divisor  = DVR_W'(fs_q);
			end
			S_HGT: begin
				div_req.start    = cal_q && (diff != '0) && (span_q != '0);
				div_req.dividend = hgt_dividend;
				div_req.divisor  = span_q;
			end
			default: ;
		endcase
	end

	// Average times reference millivolts.
	always_comb begin
		mul_req.start  = (state_q == S_AVGW) && div_done;
		mul_req.mplier = quotient[ADC_W-1:0];
		mul_req.mcand  = ref_mv_q;
	end

	// Sequencer, calibration latch and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ref_lvl_q   <= '0;
			cal_q       <= 1'b0;
			out_valid_q <= 1'b0;
			level_o_q   <= '0;
			ref_o_q     <= '0;
			height_o_q  <= '0;
			cal_o_q     <= 1'b0;
		end else begin
			// The result beat rises when loaded and drops once taken.
			if ((state_q == S_OUT) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= S_AVG;
				end
				S_AVG: begin
					state_q <= S_AVGW;
				end
				S_AVGW: begin
					if (div_done) begin
						state_q <= S_MULW;
					end
				end
				S_MULW: begin
					if (mul_done) begin
						state_q <= S_LVLW;
					end
				end
				S_LVLW: begin
					if (div_done) begin
						if (ring_full && !cal_q) begin
							ref_lvl_q <= level_sat;
							cal_q     <= 1'b1;
						end
						state_q <= S_HGT;
					end
				end
				S_HGT: begin
					if (div_req.start) begin
						state_q <= S_HGTW;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_HGTW: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						level_o_q   <= level_q;
						ref_o_q     <= ref_lvl_q;
						height_o_q  <= height_q;
						cal_o_q     <= cal_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Level and height working registers.
	always_ff @(posedge clk) begin
		if ((state_q == S_LVLW) && div_done) begin
			level_q <= level_sat;
		end
		if (state_q == S_HGT) begin
			// Zero before calibration or for equal levels; full scale by sign on zero span.
			if (!cal_q || (diff == '0)) begin
				height_q <= '0;
			end else if (span_q == '0) begin
				height_q <= diff_neg ? (PCT_W'(0) - {1'b0, PCT_MAX}) : {1'b0, PCT_MAX};
			end
		end
		if ((state_q == S_HGTW) && div_done) begin
			height_q <= diff_neg ? (PCT_W'(0) - {1'b0, hmag_sat}) : {1'b0, hmag_sat};
		end
	end

	assign out_valid      = out_valid_q;
	assign level_mv       = level_o_q;
	assign reference_mv   = ref_o_q;
	assign height_percent = height_o_q;
	assign calibrated     = cal_o_q;

endmodule

@@ hw/rtl/awah_chk.sv @@
// Port-level checker for the window average block, with its bind.
module awah_chk import awah_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [MV_W-1:0]         level_mv,
	input logic [MV_W-1:0]         reference_mv,
	input logic signed [PCT_W-1:0] height_percent,
	input logic                    calibrated
);

	// Before calibration a result carries no reference and no height.
	a_uncal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !calibrated |-> (reference_mv == '0) && (height_percent == '0))
		else $error("uncalibrated result with nonzero reference or height");

	// Calibration is never lost until reset.
	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		calibrated |=> calibrated)
		else $error("calibrated flag dropped");

	// The latched reference never moves once calibrated.
	a_ref_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		calibrated |=> $stable(reference_mv))
		else $error("reference changed after calibration");

	// Height stays within the saturation limits.
	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (height_percent <= $signed({1'b0, PCT_MAX}))
			&& (height_percent >= -$signed({1'b0, PCT_MAX})))
		else $error("height out of range");

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level_mv)
			&& $stable(height_percent))
		else $error("stalled result beat changed");

endmodule

bind adc_window_average_height awah_chk u_awah_chk (.*);

@@ test/adc_window_average_height_tb.sv @@
// Self-checking testbench for the boxcar ADC average, millivolt level and percent height block.
`timescale 1ns / 100ps

module adc_window_average_height_tb import awah_pkg::*;;

	localparam int WINDOW        = 100;
	localparam int LEVEL_LIMIT   = MV_MAX;
	localparam int HEIGHT_LIMIT  = PCT_MAX;
	localparam int PERCENT       = PCT_SCALE;
	localparam int FS_CODE_MAX   = (1 << FS_W) - 1;
	localparam int QUIET_LIMIT   = 2000;
	localparam int TAIL_CYCLES   = 64;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 150;

	// Index with no register behind it; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	typedef struct {
		logic [MV_W-1:0]         level;
		logic [MV_W-1:0]         reference;
		logic signed [PCT_W-1:0] height;
		logic                    cal;
	} height_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_idx;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [ADC_W-1:0]        adc_sample;
	logic                    out_valid;
	logic                    out_ready;
	logic [MV_W-1:0]         level_mv;
	logic [MV_W-1:0]         reference_mv;
	logic signed [PCT_W-1:0] height_percent;
	logic                    calibrated;

	// Shadow of the window state and the configuration registers.
	logic [ADC_W-1:0] win_ring [WINDOW];
	int               win_sum;
	int               win_pos;
	int               win_taken;
	int               ref_level_mv;
	logic             ref_latched;
	int               cfg_ref;
	int               cfg_fs;
	int               cfg_span;

	height_result_t expected_heights[$];
	int             mismatch_count = 0;
	int             quiet_cycles   = 0;
	logic           tx_idle        = 1'b0;
	logic           rx_idle        = 1'b0;

	adc_window_average_height #(.WINDOW(WINDOW)) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.adc_sample     (adc_sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.level_mv       (level_mv),
		.reference_mv   (reference_mv),
		.height_percent (height_percent),
		.calibrated     (calibrated)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bring the shadow state to its after-reset values.
	function automatic void clear_window_shadow();
		for (int i = 0; i < WINDOW; i++) begin
			win_ring[i] = '0;
		end
		win_sum      = 0;
		win_pos      = 0;
		win_taken    = 0;
		ref_level_mv = 0;
		ref_latched  = 1'b0;
		cfg_ref      = REF_MV_RST;
		cfg_fs       = FS_RST;
		cfg_span     = SPAN_MV_RST;
	endfunction

	// Advance the window by one sample and work out the result beat it causes.
	function automatic height_result_t predict_height(input logic [ADC_W-1:0] adc_code);
		height_result_t res;
		int avg;
		int mv;
		int diff;
		int h;
		win_sum = win_sum - int'(win_ring[win_pos]) + int'(adc_code);
		win_ring[win_pos] = adc_code;
		win_pos = (win_pos + 1 == WINDOW) ? 0 : win_pos + 1;

		avg = win_sum / WINDOW;
		if (cfg_fs == 0) begin
			mv = LEVEL_LIMIT;
		end else begin
			mv = (avg * cfg_ref) / cfg_fs;
			if (mv > LEVEL_LIMIT) mv = LEVEL_LIMIT;
		end

		// The reference is taken once, on the sample that first fills the window.
		if (win_taken < WINDOW) begin
			win_taken++;
			if (win_taken == WINDOW) begin
				ref_level_mv = mv;
				ref_latched  = 1'b1;
			end
		end

		h = 0;
		if (ref_latched) begin
			diff = (ref_level_mv - mv) * PERCENT;
			if (cfg_span == 0) begin
				h = (diff > 0) ? HEIGHT_LIMIT : (diff < 0) ? -HEIGHT_LIMIT : 0;
			end else begin
				h = diff / cfg_span;
				if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
				if (h < -HEIGHT_LIMIT) h = -HEIGHT_LIMIT;
			end
		end

		res.level     = MV_W'(mv);
		res.reference = MV_W'(ref_level_mv);
		res.height    = PCT_W'(h);
		res.cal       = ref_latched;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Predict on every input beat, check every result beat, and watch for a hang.
	always @(posedge clk) begin : result_monitor
		height_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) expected_heights.push_back(predict_height(adc_sample));
			if (out_valid && out_ready) begin
				if (expected_heights.size() == 0) begin
					report_mismatch($sformatf("result beat with none expected, level %0d",
						level_mv));
				end else begin
					want = expected_heights.pop_front();
					if (level_mv !== want.level)
						report_mismatch($sformatf("level_mv %0d, expected %0d",
							level_mv, want.level));
					if (reference_mv !== want.reference)
						report_mismatch($sformatf("reference_mv %0d, expected %0d",
							reference_mv, want.reference));
					if (height_percent !== want.height)
						report_mismatch($sformatf("height_percent %0d, expected %0d",
							height_percent, want.height));
					if (calibrated !== want.cal)
						report_mismatch($sformatf("calibrated %0b, expected %0b",
							calibrated, want.cal));
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[%0t] watchdog: no beat for %0d cycles", $time, QUIET_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Result sink: when idling, may hold ready low for a random stall once a result shows up.
	initial begin : result_sink
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = rx_idle ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				do @(posedge clk); while (!out_valid);
				repeat (stall - 1) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offer one sample and hold it until the block takes the beat.
	task automatic send_sample(input logic [ADC_W-1:0] adc_code);
		int gap;
		gap = tx_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		adc_sample <= adc_code;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop sending and wait until every predicted result has been checked.
	task automatic settle_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_heights.size() != 0) @(posedge clk);
	endtask

	// Write all three registers, plus junk to the unmapped index, with the block idle.
	task automatic write_settings(input int ref_v, input int fs_v, input int span_v);
		settle_results();
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_REF_MV;
		cfg_data <= CFG_W'(ref_v);
		@(posedge clk);
		cfg_idx  <= REG_FULL_SCALE;
		cfg_data <= CFG_W'(fs_v);
		@(posedge clk);
		cfg_idx  <= REG_SPAN_MV;
		cfg_data <= CFG_W'(span_v);
		@(posedge clk);
		cfg_idx  <= REG_UNMAPPED;
		cfg_data <= CFG_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cfg_ref  = ref_v % (1 << MV_W);
		cfg_fs   = fs_v % (1 << FS_W);
		cfg_span = span_v % (1 << MV_W);
	endtask

	// Defaults, no idling: extremes into a mostly empty ring.
	task automatic test_partial_ring();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_sample(ADC_W'(ADC_MAX));
		send_sample('0);
		send_sample(ADC_W'(ADC_MAX));
		send_sample(ADC_W'(ADC_MAX));
		send_sample(ADC_W'(512));
		send_sample(ADC_W'(1));
		send_sample(ADC_W'(ADC_MAX - 1));
		send_sample('0);
	endtask

	// Level saturation, zero full scale and zero reference before calibration.
	task automatic test_level_limits();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		write_settings(LEVEL_LIMIT, 1, 1);
		repeat (2) send_sample(ADC_W'(ADC_MAX));
		send_sample('0);
		send_sample(ADC_W'(700));
		// Upper data bits fall outside the full-scale field, leaving it zero.
		write_settings(LEVEL_LIMIT, 12'hC00, 0);
		repeat (3) send_sample(ADC_W'($urandom_range(0, ADC_MAX)));
		write_settings(0, FS_CODE_MAX, LEVEL_LIMIT);
		repeat (2) send_sample(ADC_W'(ADC_MAX));
	endtask

	// Fill the window with random samples so the reference gets latched.
	task automatic test_calibration();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		write_settings(3300, FS_CODE_MAX, 500);
		repeat (WINDOW - win_taken) send_sample(ADC_W'($urandom_range(0, ADC_MAX)));
	endtask

	// Height after calibration: zero span with equal and unequal levels, then span limits.
	task automatic test_height_limits();
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		write_settings(3300, FS_CODE_MAX, 0);
		// Replacing the oldest sample by itself keeps the level on the reference.
		repeat (2) begin
			send_sample(win_ring[win_pos]);
			settle_results();
		end
		repeat (3) send_sample(ADC_W'(ADC_MAX));
		repeat (6) send_sample('0);
		write_settings(3300, FS_CODE_MAX, 1);
		send_sample(ADC_W'(ADC_MAX));
		send_sample('0);
		write_settings(LEVEL_LIMIT, FS_CODE_MAX, LEVEL_LIMIT);
		send_sample(ADC_W'(ADC_MAX));
		send_sample('0);
	endtask

	// Random phases: new settings each phase, samples drifting around a moving level.
	task automatic test_random_phases();
		int ref_v;
		int fs_v;
		int span_v;
		int pick;
		int code;
		int drift;
		drift = 512;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 3))
				0:       ref_v = 1;
				1:       ref_v = LEVEL_LIMIT;
				default: ref_v = $urandom_range(1, LEVEL_LIMIT);
			endcase
			case ($urandom_range(0, 3))
				0:       fs_v = 1;
				1:       fs_v = FS_CODE_MAX;
				default: fs_v = $urandom_range(1, FS_CODE_MAX);
			endcase
			fs_v += $urandom_range(0, 3) << FS_W;
			case ($urandom_range(0, 3))
				0:       span_v = 1;
				1:       span_v = LEVEL_LIMIT;
				default: span_v = $urandom_range(1, LEVEL_LIMIT);
			endcase
			if (phase == RANDOM_PHASES - 1) begin
				ref_v  = REF_MV_RST;
				fs_v   = FS_RST;
				span_v = SPAN_MV_RST;
			end
			write_settings(ref_v, fs_v, span_v);
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);

			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(0, 49);
				if (pick == 0) begin
					drift = $urandom_range(0, ADC_MAX);
				end else if (pick < 36) begin
					drift += $urandom_range(0, 40) - 20;
				end
				drift = (drift < 0) ? 0 : (drift > ADC_MAX) ? ADC_MAX : drift;
				if (pick < 36) begin
					code = drift + $urandom_range(0, 16) - 8;
					code = (code < 0) ? 0 : (code > ADC_MAX) ? ADC_MAX : code;
				end else if (pick < 46) begin
					code = $urandom_range(0, ADC_MAX);
				end else begin
					code = (pick[0]) ? ADC_MAX : 0;
				end
				send_sample(ADC_W'(code));
			end
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_idx    <= REG_REF_MV;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		adc_sample <= '0;
		clear_window_shadow();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_partial_ring();
		test_level_limits();
		test_calibration();
		test_height_limits();
		test_random_phases();

		settle_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_heights.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
